### hw/rtl/sorted_delta_histogram_defines.svh
// Assertion macros shared by the sorted delta histogram RTL.
`ifndef SORTED_DELTA_HISTOGRAM_DEFINES_SVH
`define SORTED_DELTA_HISTOGRAM_DEFINES_SVH
`ifndef ASSERT_OFF
`define SDH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SDH_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`else
`define SDH_ASSERT(label, prop, msg)
`define SDH_ASSERT_IMPLY(label, pre, post, msg)
`endif
`endif

### hw/rtl/sdh_pkg.sv
// Types and constants of the sorted delta histogram.
package sdh_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int COORD_BITS  = 16;
	localparam int COORD_W     = 16;
	localparam int VALUE_W     = 17;
	localparam int COUNT_W     = 32;
	localparam int DELTA_W     = COORD_BITS + 1;
	localparam int TOTAL_W     = $clog2(TABLE_DEPTH + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COORD_BITS-1:0]     coord_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0]        count_t;
	typedef logic [TOTAL_W-1:0]        total_t;
	typedef logic [QCNT_W-1:0]         qcnt_t;

	localparam total_t TOTAL_FULL = total_t'(TABLE_DEPTH);
	localparam qcnt_t  QUEUE_FULL = qcnt_t'(QUEUE_DEPTH);

	// One request from the front to the back: insert a delta or dump the table.
	typedef struct packed {
		logic   dump;
		delta_t value;
	} op_t;

	typedef struct packed {
		total_t total;
		logic   dumping;
	} back_stat_t;
endpackage

### hw/rtl/sdh_ifs.sv
// Valid/ready channel interfaces for path points and histogram entries.
interface sdh_point_if;
	logic                        valid;
	logic                        ready;
	logic [sdh_pkg::COORD_W-1:0] x_coord;
	logic [sdh_pkg::COORD_W-1:0] y_coord;
	logic                        last_point;

	modport source(output valid, x_coord, y_coord, last_point, input ready);
	modport sink(input valid, x_coord, y_coord, last_point, output ready);
endinterface

interface sdh_entry_if;
	logic                               valid;
	logic                               ready;
	logic signed [sdh_pkg::VALUE_W-1:0] entry_value;
	logic [sdh_pkg::COUNT_W-1:0]        entry_count;
	logic                               is_last;
	logic                               empty_res;
	logic                               overflow;

	modport source(output valid, entry_value, entry_count, is_last, empty_res, overflow,
		input ready);
	modport sink(input valid, entry_value, entry_count, is_last, empty_res, overflow,
		output ready);
endinterface

### hw/rtl/sorted_delta_histogram.sv
// Sorted delta histogram: takes path points and, on the point marked last, streams out a
// table of the distinct x and y steps of the path in ascending order, each with a saturating
// count. From the second point of a path on, dx and then dy go as insert requests through a
// four-entry queue into a chain of 64 sorted cells; the chain inserts or counts one delta per
// cycle while no dump is running, and the point marked last adds a dump request, which reads
// the table entries out one by one (one result if the path had no steps). A new value that
// meets a full table is dropped and the overflow flag is set on every entry of that path's
// dump. The next path's points are taken while a dump is still running, until the queue fills.
// Results wait in an output register, so the output side may stall.
`include "sorted_delta_histogram_defines.svh"

module sorted_delta_histogram (
	input  logic        clk,
	input  logic        arst_n,
	sdh_point_if.sink   point,
	sdh_entry_if.source entry
);
	sdh_pkg::op_t        f_op;
	logic                f_valid;
	logic                f_ready;
	sdh_pkg::op_t        q_op;
	logic                q_valid;
	logic                q_ready;
	sdh_pkg::back_stat_t stat;

	sdh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.point    (point),
		.op       (f_op),
		.op_valid (f_valid),
		.op_ready (f_ready)
	);

	sdh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_op    (f_op),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_op     (q_op),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	sdh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (q_op),
		.op_valid (q_valid),
		.op_ready (q_ready),
		.entry    (entry),
		.stat     (stat)
	);

	`SDH_ASSERT(a_total_bound, stat.total <= sdh_pkg::TOTAL_FULL, "table count beyond depth")
	`SDH_ASSERT_IMPLY(a_dump_nonempty, stat.dumping, stat.total != '0, "dump with empty table")
	`SDH_ASSERT_IMPLY(a_empty_result, entry.valid && entry.empty_res, entry.is_last && (entry.entry_count == '0) && (entry.entry_value == '0), "bad empty result")
endmodule

### hw/rtl/sdh_front.sv
// Front end: takes path points, forms the deltas and issues insert and dump requests.
module sdh_front (
	input  logic            clk,
	input  logic            arst_n,
	sdh_point_if.sink       point,
	output sdh_pkg::op_t    op,
	output logic            op_valid,
	input  logic            op_ready
);
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DX   = 2'd1;
	localparam logic [1:0] PH_DY   = 2'd2;
	localparam logic [1:0] PH_DUMP = 2'd3;

	logic [1:0]      phase_q;
	logic [1:0]      phase_after;
	logic            have_prev_q;
	logic            last_q;
	sdh_pkg::coord_t prev_x_q;
	sdh_pkg::coord_t prev_y_q;
	sdh_pkg::delta_t dx_q;
	sdh_pkg::delta_t dy_q;
	sdh_pkg::coord_t x_cur;
	sdh_pkg::coord_t y_cur;
	sdh_pkg::delta_t dx_new;
	sdh_pkg::delta_t dy_new;
	logic            push;
	logic            accept;

	assign x_cur  = sdh_pkg::coord_t'(point.x_coord);
	assign y_cur  = sdh_pkg::coord_t'(point.y_coord);
	assign dx_new = {1'b0, x_cur} - {1'b0, prev_x_q};
	assign dy_new = {1'b0, y_cur} - {1'b0, prev_y_q};

	assign op_valid   = (phase_q != PH_IDLE);
	assign op.dump    = (phase_q == PH_DUMP);
	assign op.value   = (phase_q == PH_DY) ? dy_q : dx_q;
	assign push       = op_valid && op_ready;

	always_comb begin
		case (phase_q)
			PH_DX:   phase_after = PH_DY;
			PH_DY:   phase_after = last_q ? PH_DUMP : PH_IDLE;
			default: phase_after = PH_IDLE;
		endcase
	end

	// The next point is taken as the last request of the current one leaves.
	assign point.ready = (phase_q == PH_IDLE) || (push && (phase_after == PH_IDLE));
	assign accept      = point.valid && point.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else if (accept) begin
			prev_x_q    <= x_cur;
			prev_y_q    <= y_cur;
			have_prev_q <= !point.last_point;
			if (have_prev_q) begin
				phase_q <= PH_DX;
			end else if (point.last_point) begin
				phase_q <= PH_DUMP;
			end else begin
				phase_q <= PH_IDLE;
			end
		end else if (push) begin
			phase_q <= phase_after;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q   <= dx_new;
			dy_q   <= dy_new;
			last_q <= point.last_point;
		end
	end
endmodule

### hw/rtl/sdh_queue.sv
// Short request queue between the front and back ends.
module sdh_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  sdh_pkg::op_t push_op,
	input  logic         push_valid,
	output logic         push_ready,
	output sdh_pkg::op_t pop_op,
	output logic         pop_valid,
	input  logic         pop_ready
);
	sdh_pkg::op_t                slot_q [sdh_pkg::QUEUE_DEPTH];
	logic [sdh_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sdh_pkg::QPTR_W-1:0] rd_ptr_q;
	sdh_pkg::qcnt_t              count_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = (count_q != sdh_pkg::QUEUE_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_op     = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end
endmodule

### hw/rtl/sdh_back.sv
// Back end: sorted cell chain that counts deltas and streams the table out on a dump.
module sdh_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sdh_pkg::op_t       op,
	input  logic               op_valid,
	output logic               op_ready,
	sdh_entry_if.source        entry,
	output sdh_pkg::back_stat_t stat
);
	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_DUMP  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	sdh_pkg::delta_t val_q [sdh_pkg::TABLE_DEPTH];
	sdh_pkg::count_t cnt_q [sdh_pkg::TABLE_DEPTH];
	sdh_pkg::total_t total_q;
	logic            ovf_q;
	logic [1:0]      state_q;

	logic            out_valid_q;
	sdh_pkg::value_t out_value_q;
	sdh_pkg::count_t out_count_q;
	logic            out_last_q;
	logic            out_empty_q;
	logic            out_ovf_q;

	logic [sdh_pkg::TABLE_DEPTH-1:0] lt;
	logic [sdh_pkg::TABLE_DEPTH-1:0] eq;
	logic hit;
	logic full;
	logic do_insert;
	logic do_dump;
	logic out_free;
	logic do_shift;
	logic do_empty;
	logic load;

	assign op_ready  = (state_q == ST_RUN);
	assign do_insert = op_valid && op_ready && !op.dump;
	assign do_dump   = op_valid && op_ready && op.dump;
	assign out_free  = !out_valid_q || entry.ready;
	assign do_shift  = (state_q == ST_DUMP) && out_free;
	assign do_empty  = (state_q == ST_EMPTY) && out_free;
	assign load      = do_shift || do_empty;
	assign hit       = |eq;
	assign full      = (total_q == sdh_pkg::TOTAL_FULL);

	// Each cell compares the new value with its own; the occupied cells stay sorted,
	// so the cells below the value form a prefix and the insertion point is where it ends.
	for (genvar i = 0; i < sdh_pkg::TABLE_DEPTH; i++) begin : g_cell
		logic            occ;
		logic            ins_here;
		sdh_pkg::delta_t left_val;
		sdh_pkg::count_t left_cnt;
		sdh_pkg::delta_t right_val;
		sdh_pkg::count_t right_cnt;

		assign occ   = (sdh_pkg::total_t'(i) < total_q);
		assign lt[i] = occ && (val_q[i] < op.value);
		assign eq[i] = occ && (val_q[i] == op.value);

		if (i == 0) begin : g_head
			assign ins_here = 1'b1;
			assign left_val = op.value;
			assign left_cnt = '0;
		end else begin : g_body
			assign ins_here = lt[i-1];
			assign left_val = val_q[i-1];
			assign left_cnt = cnt_q[i-1];
		end

		if (i == sdh_pkg::TABLE_DEPTH - 1) begin : g_tail
			assign right_val = val_q[i];
			assign right_cnt = cnt_q[i];
		end else begin : g_inner
			assign right_val = val_q[i+1];
			assign right_cnt = cnt_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (hit) begin
					if (eq[i] && (cnt_q[i] != '1)) begin
						cnt_q[i] <= cnt_q[i] + 1'b1;
					end
				end else if (!full && !lt[i]) begin
					if (ins_here) begin
						val_q[i] <= op.value;
						cnt_q[i] <= sdh_pkg::count_t'(1);
					end else begin
						val_q[i] <= left_val;
						cnt_q[i] <= left_cnt;
					end
				end
			end else if (do_shift) begin
				val_q[i] <= right_val;
				cnt_q[i] <= right_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (do_dump) begin
						state_q <= (total_q == '0) ? ST_EMPTY : ST_DUMP;
					end
				end
				ST_DUMP: begin
					if (do_shift && (total_q == sdh_pkg::total_t'(1))) begin
						state_q <= ST_RUN;
					end
				end
				ST_EMPTY: begin
					if (do_empty) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase

			if (do_insert && !hit && !full) begin
				total_q <= total_q + 1'b1;
			end else if (do_shift) begin
				total_q <= total_q - 1'b1;
			end

			if (do_insert && !hit && full) begin
				ovf_q <= 1'b1;
			end else if (do_empty || (do_shift && (total_q == sdh_pkg::total_t'(1)))) begin
				ovf_q <= 1'b0;
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (entry.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q <= do_shift ? sdh_pkg::value_t'(val_q[0]) : '0;
			out_count_q <= do_shift ? cnt_q[0] : '0;
			out_last_q  <= do_empty || (total_q == sdh_pkg::total_t'(1));
			out_empty_q <= do_empty;
			out_ovf_q   <= ovf_q;
		end
	end

	assign entry.valid       = out_valid_q;
	assign entry.entry_value = out_value_q;
	assign entry.entry_count = out_count_q;
	assign entry.is_last     = out_last_q;
	assign entry.empty_res   = out_empty_q;
	assign entry.overflow    = out_ovf_q;

	assign stat.total   = total_q;
	assign stat.dumping = (state_q == ST_DUMP);
endmodule

### tb/sdh_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted delta histogram: predicts each dump and compares it entry by entry.
module sdh_checker
	import sdh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sdh_point_if point,
	sdh_entry_if entry,
	output int   fail_count,
	output int   pending,
	output int   entries_checked,
	output int   paths_done,
	output int   spill_paths
);
	typedef struct {
		value_t value;
		count_t count;
		logic   is_last;
		logic   empty_res;
		logic   overflow;
	} hist_entry_t;

	// Predicted table of the path in progress, kept sorted by value.
	delta_t      bin_value[TABLE_DEPTH];
	count_t      bin_count[TABLE_DEPTH];
	int          bin_total;
	logic        bin_dropped;
	coord_t      prev_x;
	coord_t      prev_y;
	logic        path_open;
	hist_entry_t dump_queue[$];
	int          fails;
	int          checked;
	int          paths;
	int          spills;

	function automatic void tally_step(input delta_t step);
		int pos;
		pos = 0;
		while (pos < bin_total && bin_value[pos] < step)
			pos++;
		if (pos < bin_total && bin_value[pos] == step) begin
			if (bin_count[pos] != '1)
				bin_count[pos]++;
		end else if (bin_total >= TABLE_DEPTH) begin
			bin_dropped = 1'b1;
		end else begin
			for (int k = bin_total; k > pos; k--) begin
				bin_value[k] = bin_value[k-1];
				bin_count[k] = bin_count[k-1];
			end
			bin_value[pos] = step;
			bin_count[pos] = 1;
			bin_total++;
		end
	endfunction

	function automatic void dump_path();
		hist_entry_t item;
		if (bin_total == 0) begin
			item.value     = '0;
			item.count     = '0;
			item.is_last   = 1'b1;
			item.empty_res = 1'b1;
			item.overflow  = bin_dropped;
			dump_queue.push_back(item);
		end else begin
			for (int k = 0; k < bin_total; k++) begin
				item.value     = value_t'(bin_value[k]);
				item.count     = bin_count[k];
				item.is_last   = (k == bin_total - 1);
				item.empty_res = 1'b0;
				item.overflow  = bin_dropped;
				dump_queue.push_back(item);
			end
		end
		if (bin_dropped)
			spills++;
		paths++;
		path_open   = 1'b0;
		bin_total   = 0;
		bin_dropped = 1'b0;
	endfunction

	function automatic void predict_point(input coord_t x, input coord_t y, input logic last);
		if (path_open) begin
			tally_step($signed({1'b0, x}) - $signed({1'b0, prev_x}));
			tally_step($signed({1'b0, y}) - $signed({1'b0, prev_y}));
		end
		prev_x    = x;
		prev_y    = y;
		path_open = 1'b1;
		if (last)
			dump_path();
	endfunction

	function automatic void check_entry(input hist_entry_t got);
		hist_entry_t want;
		if (dump_queue.size() == 0) begin
			$error("unexpected histogram entry: entry_value %0d entry_count %0d",
				got.value, got.count);
			fails++;
		end else begin
			want = dump_queue.pop_front();
			if (got.value !== want.value) begin
				$error("entry_value: expected %0d, actual %0d", want.value, got.value);
				fails++;
			end
			if (got.count !== want.count) begin
				$error("entry_count: expected %0d, actual %0d", want.count, got.count);
				fails++;
			end
			if (got.is_last !== want.is_last) begin
				$error("is_last: expected %b, actual %b", want.is_last, got.is_last);
				fails++;
			end
			if (got.empty_res !== want.empty_res) begin
				$error("empty_res: expected %b, actual %b", want.empty_res, got.empty_res);
				fails++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %b, actual %b", want.overflow, got.overflow);
				fails++;
			end
		end
		checked++;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		hist_entry_t got;
		if (!arst_n) begin
			dump_queue.delete();
			bin_total   = 0;
			bin_dropped = 1'b0;
			prev_x      = '0;
			prev_y      = '0;
			path_open   = 1'b0;
		end else begin
			// Results go first: a point taken at this edge cannot have produced one yet.
			if (entry.valid && entry.ready) begin
				got.value     = entry.entry_value;
				got.count     = entry.entry_count;
				got.is_last   = entry.is_last;
				got.empty_res = entry.empty_res;
				got.overflow  = entry.overflow;
				check_entry(got);
			end
			if (point.valid && point.ready)
				predict_point(coord_t'(point.x_coord), coord_t'(point.y_coord),
					point.last_point);
		end
		fail_count      <= fails;
		pending         <= dump_queue.size();
		entries_checked <= checked;
		paths_done      <= paths;
		spill_paths     <= spills;
	end
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the sorted delta histogram testbench: clock, reset, path stimulus and verdict.
module testbench;
	import sdh_pkg::*;

	localparam int ITEM_TARGET = 310;
	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 150;

	typedef enum {PATH_SINGLE, PATH_WIDE, PATH_STEPS, PATH_SPILL} path_kind_t;
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

	logic clk;
	logic arst_n;
	logic hold_go;
	int   fail_count;
	int   pending;
	int   entries_checked;
	int   paths_done;
	int   spill_paths;
	int   points_sent;
	int   burst_left;

	sdh_point_if point_ch();
	sdh_entry_if entry_ch();

	sorted_delta_histogram uut (
		.clk   (clk),
		.arst_n(arst_n),
		.point (point_ch),
		.entry (entry_ch)
	);

	sdh_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.point          (point_ch),
		.entry          (entry_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.entries_checked(entries_checked),
		.paths_done     (paths_done),
		.spill_paths    (spill_paths)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offers one point and returns at the edge where the request is taken.
	task automatic send_point(input coord_t x, input coord_t y, input logic last);
		if (burst_left == 0) begin
			point_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
		end
		point_ch.valid      <= 1'b1;
		point_ch.x_coord    <= x;
		point_ch.y_coord    <= y;
		point_ch.last_point <= last;
		@(posedge clk);
		while (!point_ch.ready)
			@(posedge clk);
		burst_left--;
		points_sent++;
	endtask

	task automatic wait_for_dump();
		point_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic run_path(input path_kind_t kind);
		int     len;
		coord_t x;
		coord_t y;
		case (kind)
			PATH_SINGLE: len = 1;
			PATH_WIDE:   len = $urandom_range(2, 8);
			PATH_STEPS:  len = $urandom_range(3, 20);
			default:     len = $urandom_range(36, 45);
		endcase
		x = coord_t'($urandom);
		y = coord_t'($urandom);
		for (int i = 0; i < len; i++) begin
			if (i > 0) begin
				// Small steps repeat often, so counts climb; wide paths give distinct values.
				if (kind == PATH_STEPS) begin
					x = x + coord_t'($urandom_range(0, 8) - 4);
					y = y + coord_t'($urandom_range(0, 8) - 4);
				end else begin
					x = coord_t'($urandom);
					y = coord_t'($urandom);
				end
			end
			send_point(x, y, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int         path_idx;
		path_kind_t kind;
		points_sent          = 0;
		burst_left           = 0;
		arst_n              <= 1'b0;
		hold_go             <= 1'b0;
		point_ch.valid      <= 1'b0;
		point_ch.x_coord    <= '0;
		point_ch.y_coord    <= '0;
		point_ch.last_point <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A single point gives an empty dump.
		send_point(16'd1234, 16'd4321, 1'b1);
		// Largest positive and negative steps.
		send_point(16'h0000, 16'h0000, 1'b0);
		send_point(16'hFFFF, 16'hFFFF, 1'b1);
		send_point(16'hFFFF, 16'hFFFF, 1'b0);
		send_point(16'h0000, 16'h0000, 1'b1);
		send_point(16'h0000, 16'hFFFF, 1'b0);
		send_point(16'hFFFF, 16'h0000, 1'b1);
		send_point(16'd5, 16'd5, 1'b0);
		send_point(16'd5, 16'd5, 1'b1);
		// Repeated steps of both signs, with the last point's steps counted too.
		send_point(16'd100, 16'd200, 1'b0);
		send_point(16'd103, 16'd198, 1'b0);
		send_point(16'd106, 16'd196, 1'b0);
		send_point(16'd104, 16'd199, 1'b0);
		send_point(16'd104, 16'd199, 1'b1);
		send_point(16'd7, 16'd9, 1'b1);
		send_point(16'd9, 16'd7, 1'b1);
		send_point(16'h8000, 16'h7FFF, 1'b0);
		send_point(16'h7FFF, 16'h8000, 1'b0);
		send_point(16'hFFFF, 16'h0001, 1'b1);

		// The output side now holds off for a long stretch while paths keep coming.
		hold_go <= 1'b1;
		path_idx = 0;
		while (points_sent < ITEM_TARGET) begin
			if (path_idx == 0 || path_idx == 12) begin
				kind = PATH_SPILL;
			end else begin
				case ($urandom_range(0, 9))
					0, 1:    kind = PATH_SINGLE;
					2, 3, 4: kind = PATH_WIDE;
					default: kind = PATH_STEPS;
				endcase
			end
			run_path(kind);
			if (path_idx == 8)
				wait_for_dump();
			path_idx++;
		end

		point_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Summary: %0d points in %0d paths, %0d of them past the table depth.",
			points_sent, paths_done, spill_paths);
		$display("Summary: %0d histogram entries checked, with one long output stall.",
			entries_checked);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin : result_side
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		bit       hold_used;
		mode      = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		hold_used = 1'b0;
		entry_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				entry_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					RX_OPEN:  entry_ch.ready <= 1'b1;
					RX_COIN:  entry_ch.ready <= 1'($urandom_range(0, 1));
					default:  entry_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((point_ch.valid && point_ch.ready) || (entry_ch.valid && entry_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Watchdog: no request moved for %0d cycles.", IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end
endmodule
